// ----- src/dual_stepper_lift_controller_top_macros.svh -----
// ----------------------------------------------------------------------------
// Dual stepper lift controller - assertion macros
// Shared property wrappers used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_LIFT_CONTROLLER_TOP_MACROS_SVH
`define DUAL_STEPPER_LIFT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define DSLC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dslc check failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define DSLC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dslc check failed");

`endif

// ----- src/dslc_pkg.sv -----
// ----------------------------------------------------------------------------
// dslc_pkg
// Types, codes and constants shared by the dual stepper lift controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dslc_pkg;

  // Defaults
  localparam int unsigned POSITION_WIDTH_DEF = 16;
  localparam logic [7:0]  CLEARANCE_RESET    = 8'd10;

  // Register map (word index = paddr[2])
  localparam int unsigned PADDR_WIDTH   = 3;
  localparam logic        REG_CLEARANCE = 1'b0;

  // Command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_HOME = 2'd2
  } cmd_e;

  // Homing phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_DOWN_BOTH  = 3'd1,
    PH_DOWN_LEFT  = 3'd2,
    PH_DOWN_RIGHT = 3'd3,
    PH_UP_BOTH    = 3'd4,
    PH_UP_RIGHT   = 3'd5,
    PH_UP_LEFT    = 3'd6,
    PH_CLEAR      = 3'd7
  } phase_e;

  // One input item
  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] new_target;
    logic               estop_active;
    logic               left_endstop_open;
    logic               right_endstop_open;
    logic               left_fault;
    logic               right_fault;
  } item_t;

  // One result item
  typedef struct packed {
    logic               left_step;
    logic               right_step;
    logic               left_dir;
    logic               right_dir;
    logic               drivers_awake;
    logic               moving;
    logic               homing;
    logic signed [15:0] position;
  } result_t;

endpackage

`default_nettype wire

// ----- src/dslc_apb_regs.sv -----
// ----------------------------------------------------------------------------
// dslc_apb_regs
// APB register file holding the homing clearance step count.
// ----------------------------------------------------------------------------
`default_nettype none

module dslc_apb_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dslc_pkg::PADDR_WIDTH-1:0]   paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  output logic [7:0]                              clearance_steps_o
);
  import dslc_pkg::*;

  logic [7:0] clearance_q;
  logic [7:0] clearance_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode
  always_comb begin
    clearance_d = clearance_q;
    if (wr_en && (paddr[2] == REG_CLEARANCE)) begin
      clearance_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearance_q <= CLEARANCE_RESET;
    end else begin
      clearance_q <= clearance_d;
    end
  end

  // Read mux; low address bits are ignored
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_CLEARANCE) begin
      prdata = {24'd0, clearance_q};
    end
  end

  assign clearance_steps_o = clearance_q;

endmodule

`default_nettype wire

// ----- src/dslc_step_core.sv -----
// ----------------------------------------------------------------------------
// dslc_step_core
// Lift state (position, target, homing phase, clearance count, wake flag)
// and the single-pass logic that applies one item to it.
// ----------------------------------------------------------------------------
`default_nettype none

module dslc_step_core #(
  parameter int unsigned POSITION_WIDTH = dslc_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire dslc_pkg::item_t  item_i,
  input  wire logic [7:0]       clearance_steps_i,
  output dslc_pkg::result_t     result_o
);
  import dslc_pkg::*;

  phase_e                    phase_q, phase_d;
  logic [7:0]                clear_q, clear_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [POSITION_WIDTH-1:0] tgt_q, tgt_d;
  logic                      awake_q, awake_d;

  logic                      is_tick;
  logic                      go;
  logic                      h_ls, h_rs, h_ld, h_rd;
  logic                      p_ls, p_ld, moving;
  logic signed [31:0]        tgt_sx;
  logic [31:0]               pos_zx;
  logic                      at_target;
  logic                      tgt_above;

  assign is_tick = (item_i.command == CMD_TICK);

  // Homing phase outputs: step/dir while the phase condition holds
  always_comb begin
    go   = 1'b0;
    h_ls = 1'b0;
    h_rs = 1'b0;
    h_ld = 1'b0;
    h_rd = 1'b0;
    case (phase_q)
      PH_DOWN_BOTH: begin
        go   = item_i.left_endstop_open && item_i.right_endstop_open;
        h_ls = go;
        h_rs = go;
      end
      PH_DOWN_LEFT: begin
        go   = item_i.left_endstop_open;
        h_ls = go;
      end
      PH_DOWN_RIGHT: begin
        go   = item_i.right_endstop_open;
        h_rs = go;
      end
      PH_UP_BOTH: begin
        go   = !item_i.left_endstop_open && !item_i.right_endstop_open;
        h_ls = go;
        h_rs = go;
        h_ld = go;
        h_rd = go;
      end
      PH_UP_RIGHT: begin
        go   = !item_i.right_endstop_open;
        h_rs = go;
        h_rd = go;
      end
      PH_UP_LEFT: begin
        go   = !item_i.left_endstop_open;
        h_ls = go;
        h_ld = go;
      end
      PH_CLEAR: begin
        go   = clear_q < clearance_steps_i;
        h_ls = go;
        h_rs = go;
        h_ld = go;
        h_rd = go;
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // Homing phase next state
  always_comb begin
    phase_d = phase_q;
    case (item_i.command)
      CMD_HOME: begin
        if (!item_i.estop_active) begin
          phase_d = PH_DOWN_BOTH;
        end
      end
      CMD_TICK: begin
        if ((phase_q != PH_IDLE) && !go) begin
          phase_d = (phase_q == PH_CLEAR) ? PH_IDLE : phase_e'(phase_q + 3'd1);
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Positioning compare
  assign at_target = (pos_q == tgt_q);
  assign tgt_above = ($signed(tgt_q) > $signed(pos_q));

  // New target: sign-extend the field, then wrap to the position width
  assign tgt_sx = 32'(item_i.new_target);

  // Datapath next state
  always_comb begin
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    clear_d = clear_q;
    awake_d = awake_q;
    p_ls    = 1'b0;
    p_ld    = 1'b0;
    moving  = 1'b0;
    case (item_i.command)
      CMD_LOAD: begin
        if (phase_q == PH_IDLE) begin
          tgt_d = tgt_sx[POSITION_WIDTH-1:0];
        end
      end
      CMD_HOME: begin
        if (!item_i.estop_active) begin
          awake_d = 1'b1;
          clear_d = 8'd0;
        end
      end
      CMD_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (phase_q == PH_CLEAR) begin
            if (go) begin
              clear_d = clear_q + 8'd1;
            end else begin
              pos_d = '0;
              tgt_d = '0;
            end
          end
        end else if (item_i.estop_active || at_target) begin
          awake_d = 1'b0;
        end else begin
          if (item_i.left_fault || item_i.right_fault) begin
            awake_d = 1'b1;
          end
          p_ls   = 1'b1;
          moving = 1'b1;
          if (tgt_above) begin
            p_ld  = 1'b1;
            pos_d = pos_q + POSITION_WIDTH'(1);
          end else begin
            pos_d = pos_q - POSITION_WIDTH'(1);
          end
        end
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      clear_q <= 8'd0;
      pos_q   <= '0;
      tgt_q   <= '0;
      awake_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      clear_q <= clear_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      awake_q <= awake_d;
    end
  end

  // Result: low 16 bits of the updated position
  assign pos_zx = 32'(pos_d);

  always_comb begin
    result_o.left_step     = is_tick && ((phase_q != PH_IDLE) ? h_ls : p_ls);
    result_o.right_step    = is_tick && ((phase_q != PH_IDLE) ? h_rs : p_ls);
    result_o.left_dir      = is_tick && ((phase_q != PH_IDLE) ? h_ld : p_ld);
    result_o.right_dir     = is_tick && ((phase_q != PH_IDLE) ? h_rd : p_ld);
    result_o.drivers_awake = awake_d;
    result_o.moving        = moving;
    result_o.homing        = (phase_d != PH_IDLE);
    result_o.position      = pos_zx[15:0];
  end

endmodule

`default_nettype wire

// ----- src/dual_stepper_lift_controller_top.sv -----
// ----------------------------------------------------------------------------
// dual_stepper_lift_controller_top
// Two-motor lift positioning with seven-phase endstop homing.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o  | command, new_target, estop, endstops,
//           |                          | faults
//  out      | out_valid_o / out_ready_i| step, dir, awake, moving, homing, pos
//  cfg      | APB psel/penable/pwrite  | clearance_steps at byte address 0
//
// One item per clock unless the output stalls; items pass the input register,
// then the result register; state is updated as an item enters the latter.
// Reset clears position, target, phase, count and wake flag; clearance = 10.
// A stalled output holds its result while the input register still takes
// one more item; in_ready_o drops only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_stepper_lift_controller_top_macros.svh"

module dual_stepper_lift_controller_top #(
  parameter int unsigned POSITION_WIDTH = dslc_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        command_i,
  input  wire logic signed [15:0]                new_target_i,
  input  wire logic                              estop_active_i,
  input  wire logic                              left_endstop_open_i,
  input  wire logic                              right_endstop_open_i,
  input  wire logic                              left_fault_i,
  input  wire logic                              right_fault_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   left_step_o,
  output logic                                   right_step_o,
  output logic                                   left_dir_o,
  output logic                                   right_dir_o,
  output logic                                   drivers_awake_o,
  output logic                                   moving_o,
  output logic                                   homing_o,
  output logic signed [15:0]                     position_o,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dslc_pkg::PADDR_WIDTH-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import dslc_pkg::*;

  logic       in_valid_q;
  item_t      in_item_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    core_res;
  logic       advance;
  logic [7:0] clearance_steps;

  // Config registers
  dslc_apb_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .clearance_steps_o (clearance_steps)
  );

  // Pipeline control: move when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.command            <= command_i;
      in_item_q.new_target         <= new_target_i;
      in_item_q.estop_active       <= estop_active_i;
      in_item_q.left_endstop_open  <= left_endstop_open_i;
      in_item_q.right_endstop_open <= right_endstop_open_i;
      in_item_q.left_fault         <= left_fault_i;
      in_item_q.right_fault        <= right_fault_i;
    end
  end

  // Lift state and per-item logic
  dslc_step_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (advance),
    .item_i            (in_item_q),
    .clearance_steps_i (clearance_steps),
    .result_o          (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_step_o     = out_res_q.left_step;
  assign right_step_o    = out_res_q.right_step;
  assign left_dir_o      = out_res_q.left_dir;
  assign right_dir_o     = out_res_q.right_dir;
  assign drivers_awake_o = out_res_q.drivers_awake;
  assign moving_o        = out_res_q.moving;
  assign homing_o        = out_res_q.homing;
  assign position_o      = out_res_q.position;

  // Checks
  `DSLC_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i)
  `DSLC_ASSERT_IMPL(a_move_not_homing, clk_i, rst_ni, out_valid_o && moving_o, !homing_o && left_step_o && right_step_o)
  `DSLC_ASSERT_IMPL(a_dir_needs_step, clk_i, rst_ni, out_valid_o && (left_dir_o || right_dir_o), (left_step_o || !left_dir_o) && (right_step_o || !right_dir_o))
  `DSLC_ASSERT_NEXT(a_transfer_loads_result, clk_i, rst_ni, advance, out_valid_o)

endmodule

`default_nettype wire
